>>> sv/ple_pkg.sv
// Package for the positional list engine.
// Holds field widths, operation and status codes and the result struct.
// No dependencies.
`default_nettype none

package ple_pkg;

    localparam int DEPTH_DEF   = 64;
    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int POS_W       = 7;
    localparam int CNT_OUT_W   = 7;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_READ      = 3'd6
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef struct packed {
        t_status                    status;
        logic [CNT_OUT_W-1:0]       count;
        logic signed [DATA_W-1:0]   read_value;
    } t_result;

endpackage

`default_nettype wire

>>> sv/ple_mem.sv
// Entry store of the positional list engine: one write port and one read
// port with registered read data. Uses ple_pkg for the data width.
`default_nettype none

module ple_mem #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire logic [ple_pkg::DATA_W-1:0]       i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic      [ple_pkg::DATA_W-1:0]       o_rdata
);

    logic [ple_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [ple_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/ple_seq.sv
// Sequencer of the positional list engine: decodes one operation, checks the
// position and moves entries one at a time through the store. Uses ple_pkg.
`default_nettype none

module ple_seq #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire ple_pkg::t_opcode                     i_opcode,
    input  wire logic signed [ple_pkg::DATA_W-1:0]    i_value,
    input  wire logic        [ple_pkg::POS_W-1:0]     i_position,
    output logic                                      o_res_valid,
    input  wire logic                                 i_res_ready,
    output ple_pkg::t_result                          o_result,
    output logic                                      o_mem_we,
    output logic        [$clog2(DEPTH)-1:0]           o_mem_waddr,
    output logic        [ple_pkg::DATA_W-1:0]         o_mem_wdata,
    output logic        [$clog2(DEPTH)-1:0]           o_mem_raddr,
    input  wire logic   [ple_pkg::DATA_W-1:0]         i_mem_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_WR,
        S_PUT,
        S_DN_RD,
        S_DN_WR,
        S_RD_WAIT,
        S_RESP
    } t_state;

    t_state                          r_state, n_state;
    logic [CW-1:0]                   r_count, n_count;
    logic [AW-1:0]                   r_idx, n_idx;
    logic [AW-1:0]                   r_dst, n_dst;
    logic signed [ple_pkg::DATA_W-1:0] r_value, n_value;
    logic [ple_pkg::DATA_W-1:0]      r_rdata, n_rdata;
    ple_pkg::t_status                r_status, n_status;

    logic [PW-1:0] pos_x;
    logic [PW-1:0] cnt_x;
    logic [PW-1:0] pos_m1;
    logic [AW-1:0] pos_idx;
    logic [AW-1:0] cnt_idx;
    logic          pos_ok_ins;
    logic          pos_ok_ext;
    logic          full;
    logic          empty;
    logic [AW-1:0] ins_idx;
    logic [AW-1:0] del_idx;
    logic [AW-1:0] dst_dec;
    logic [AW-1:0] dst_inc;

    always_comb begin
        pos_x      = PW'(i_position);
        cnt_x      = PW'(r_count);
        pos_m1     = pos_x - PW'(1);
        pos_idx    = pos_m1[AW-1:0];
        cnt_idx    = r_count[AW-1:0];
        pos_ok_ins = (pos_x != '0) && (pos_x <= cnt_x + PW'(1));
        pos_ok_ext = (pos_x != '0) && (pos_x <= cnt_x);
        full       = (r_count == CW'(DEPTH));
        empty      = (r_count == '0);
        dst_dec    = r_dst - AW'(1);
        dst_inc    = r_dst + AW'(1);
    end

    always_comb begin
        case (i_opcode)
            ple_pkg::OP_INS_FRONT: ins_idx = '0;
            ple_pkg::OP_INS_BACK:  ins_idx = cnt_idx;
            default:               ins_idx = pos_idx;
        endcase
        case (i_opcode)
            ple_pkg::OP_DEL_FRONT: del_idx = '0;
            ple_pkg::OP_DEL_BACK:  del_idx = cnt_idx - AW'(1);
            default:               del_idx = pos_idx;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_dst    = r_dst;
        n_value  = r_value;
        n_rdata  = r_rdata;
        n_status = r_status;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_value  = i_value;
                    n_rdata  = '0;
                    n_status = ple_pkg::ST_OK;
                    n_state  = S_RESP;
                    case (i_opcode)
                        ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK,
                        ple_pkg::OP_INS_AT: begin
                            // Fullness takes priority over the position check.
                            if (full) begin
                                n_status = ple_pkg::ST_FULL;
                            end else if (i_opcode == ple_pkg::OP_INS_AT && !pos_ok_ins) begin
                                n_status = ple_pkg::ST_BADPOS;
                            end else begin
                                n_idx   = ins_idx;
                                n_dst   = cnt_idx;
                                n_state = (cnt_idx != ins_idx) ? S_UP_RD : S_PUT;
                            end
                        end
                        ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK: begin
                            if (empty) begin
                                n_status = ple_pkg::ST_EMPTY;
                            end else begin
                                n_dst = del_idx;
                                if (CW'(del_idx) + CW'(1) < r_count) begin
                                    n_state = S_DN_RD;
                                end else begin
                                    n_count = r_count - CW'(1);
                                end
                            end
                        end
                        ple_pkg::OP_DEL_AT: begin
                            if (!pos_ok_ext) begin
                                n_status = ple_pkg::ST_BADPOS;
                            end else begin
                                n_dst = del_idx;
                                if (CW'(del_idx) + CW'(1) < r_count) begin
                                    n_state = S_DN_RD;
                                end else begin
                                    n_count = r_count - CW'(1);
                                end
                            end
                        end
                        ple_pkg::OP_READ: begin
                            if (!pos_ok_ext) begin
                                n_status = ple_pkg::ST_BADPOS;
                            end else begin
                                n_state = S_RD_WAIT;
                            end
                        end
                        default: begin
                            n_status = ple_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_UP_RD: begin
                n_state = S_UP_WR;
            end
            S_UP_WR: begin
                n_dst   = dst_dec;
                n_state = (dst_dec == r_idx) ? S_PUT : S_UP_RD;
            end
            S_PUT: begin
                n_count = r_count + CW'(1);
                n_state = S_RESP;
            end
            S_DN_RD: begin
                n_state = S_DN_WR;
            end
            S_DN_WR: begin
                n_dst = dst_inc;
                if (CW'(dst_inc) + CW'(1) < r_count) begin
                    n_state = S_DN_RD;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_RESP;
                end
            end
            S_RD_WAIT: begin
                n_rdata = i_mem_rdata;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_status <= ple_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_status <= n_status;
        end
        r_idx   <= n_idx;
        r_dst   <= n_dst;
        r_value <= n_value;
        r_rdata <= n_rdata;
    end

    // The read address is the source of the next move; in idle it is the
    // addressed entry so that a read has its data in the cycle after it is accepted.
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_dst;
        o_mem_wdata = i_mem_rdata;
        case (r_state)
            S_IDLE:  o_mem_raddr = pos_idx;
            S_UP_RD: o_mem_raddr = dst_dec;
            S_DN_RD: o_mem_raddr = dst_inc;
            default: o_mem_raddr = r_dst;
        endcase
        case (r_state)
            S_UP_WR, S_DN_WR: begin
                o_mem_we = 1'b1;
            end
            S_PUT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_idx;
                o_mem_wdata = r_value;
            end
            default: begin
                o_mem_we = 1'b0;
            end
        endcase
    end

    assign o_in_ready          = (r_state == S_IDLE);
    assign o_res_valid         = (r_state == S_RESP);
    assign o_result.status     = r_status;
    assign o_result.count      = ple_pkg::CNT_OUT_W'(r_count);
    assign o_result.read_value = r_rdata;

endmodule

`default_nettype wire

>>> sv/positional_list_engine.sv
// Positional list engine: a bounded ordered list with insert, delete and read.
// An insert or a delete moves the entries that it shifts one at a time, each by one
// read and one store write. One transaction at a time: the next is taken only once
// the result has been passed to the output register.
// Synchronous active-low reset clears the count; the entry store is not cleared.
`default_nettype none

module positional_list_engine #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: value [31:0], position [38:32], zero pad [39]
    input  wire logic [ple_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: opcode [2:0]
    input  wire logic [ple_pkg::OP_W-1:0]          s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata: count [6:0], read_value [38:7], zero pad [39]
    output logic [ple_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // tuser: status [1:0]
    output logic [ple_pkg::STATUS_W-1:0]           m_axis_tuser
);

    localparam int AW = $clog2(DEPTH);
    localparam int DW = ple_pkg::DATA_W;

    logic              w_res_valid;
    logic              w_res_ready;
    ple_pkg::t_result  w_result;
    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [DW-1:0]     w_mem_wdata;
    logic [AW-1:0]     w_mem_raddr;
    logic [DW-1:0]     w_mem_rdata;

    logic              r_out_valid;
    ple_pkg::t_result  r_out;

    ple_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_opcode    (ple_pkg::t_opcode'(s_axis_tuser)),
        .i_value     (s_axis_tdata[DW-1:0]),
        .i_position  (s_axis_tdata[DW +: ple_pkg::POS_W]),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_result    (w_result),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    ple_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // The output register takes in a result when it is empty or when the downstream
    // side takes its present one; only then is the sequencer freed.
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
        if (w_res_ready && w_res_valid) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {1'b0, r_out.read_value, r_out.count};

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("New transaction taken while the previous one was in progress.");

    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> !s_axis_tready)
        else $error("Input ready while a result is pending in the sequencer.");

    a_zero_data_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (r_out.status != ple_pkg::ST_OK) |-> (r_out.read_value == '0))
        else $error("Non-zero read data returned with an error status.");
`endif

endmodule

`default_nettype wire
